### sv/psr_pkg.sv
// Particle slot recycler: shared types, widths and codes.
// Used by psr_ctrl, psr_dp, particle_slot_recycler and the verif files; depends on nothing.
package psr_pkg;

  localparam int unsigned DT_W    = 10;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned AGE_W   = 16;
  localparam int unsigned EMIT_W  = 9;
  localparam int unsigned IVL_W   = 10;
  localparam int unsigned ACT_W   = 9;
  localparam int unsigned LOOP_W  = 1;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFGI_W  = 2;
  localparam int unsigned ACC_W   = IVL_W;       // stored remainder stays below the interval
  localparam int unsigned SUM_W   = ACC_W + 1;   // accumulator plus one tick
  localparam int unsigned DSTEP_W = $clog2(SUM_W);
  localparam int unsigned REQ_W   = 2;

  localparam logic [IVL_W-1:0]  IVL_MIN  = IVL_W'(1);
  localparam logic [EMIT_W-1:0] EMIT_MAX = '1;
  localparam logic [AGE_W-1:0]  AGE_MAX  = '1;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK    = 2'd0,
    REQ_READ    = 2'd1,
    REQ_RESTART = 2'd2
  } req_e;

  typedef enum logic [CFGI_W-1:0] {
    CFG_LOOP     = 2'd0,
    CFG_INTERVAL = 2'd1,
    CFG_LIFE     = 2'd2,
    CFG_ACTIVE   = 2'd3
  } cfg_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_DIV,
    ST_RECYCLE,
    ST_SWEEP,
    ST_RDWAIT,
    ST_FILL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic latch;         // capture input transfer, clear result fields
    logic acc_sum;       // accumulator takes accumulator + dt
    logic acc_clear;
    logic acc_rem;       // accumulator takes divider remainder
    logic div_start;
    logic div_step;
    logic sweep_start;
    logic sweep_fill;    // fill sweep (no read) instead of aging sweep
    logic sweep_cfg;     // fill value from config, else zero
    logic sweep_recycle; // aging sweep also recycles expired slots
    logic sweep_run;
    logic rd_issue;
    logic rd_capture;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    req_e req;
    logic loop;
    logic sum_gt;
    logic div_last;
    logic sweep_done;
    logic out_free;
  } sts_t;

endpackage

### sv/psr_ctrl.sv
// Particle slot recycler: controller state machine.
// Depends on psr_pkg; drives psr_dp through cmd_t and watches sts_t.
module psr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  psr_pkg::sts_t sts_i,
  output logic          in_ready_o,
  output psr_pkg::cmd_t cmd_o
);
  import psr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.sweep_start = 1'b1;
        cmd_o.sweep_fill  = 1'b1;
        state_d           = ST_CLEAR;
      end
      ST_CLEAR: begin
        cmd_o.sweep_run = 1'b1;
        if (sts_i.sweep_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (sts_i.req)
          REQ_TICK: begin
            if (!sts_i.loop) begin
              cmd_o.sweep_start = 1'b1;
              state_d           = ST_SWEEP;
            end else if (sts_i.sum_gt) begin
              cmd_o.div_start = 1'b1;
              state_d         = ST_DIV;
            end else begin
              cmd_o.acc_sum = 1'b1;
              state_d       = ST_DONE;
            end
          end
          REQ_READ: begin
            cmd_o.rd_issue = 1'b1;
            state_d        = ST_RDWAIT;
          end
          REQ_RESTART: begin
            cmd_o.acc_clear   = 1'b1;
            cmd_o.sweep_start = 1'b1;
            cmd_o.sweep_fill  = 1'b1;
            cmd_o.sweep_cfg   = 1'b1;
            state_d           = ST_FILL;
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_RECYCLE;
        end
      end
      ST_RECYCLE: begin
        cmd_o.acc_rem       = 1'b1;
        cmd_o.sweep_start   = 1'b1;
        cmd_o.sweep_recycle = 1'b1;
        state_d             = ST_SWEEP;
      end
      ST_SWEEP: begin
        cmd_o.sweep_run = 1'b1;
        if (sts_i.sweep_done) begin
          state_d = ST_DONE;
        end
      end
      ST_FILL: begin
        cmd_o.sweep_run = 1'b1;
        if (sts_i.sweep_done) begin
          state_d = ST_DONE;
        end
      end
      ST_RDWAIT: begin
        cmd_o.rd_capture = 1'b1;
        state_d          = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

endmodule

### sv/psr_dp.sv
// Particle slot recycler: datapath with config registers, age memory,
// accumulator, bit-serial divider, slot sweep and output register. Depends on psr_pkg.
module psr_dp #(
  parameter int unsigned SLOTS = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [psr_pkg::CFGI_W-1:0]    cfg_idx_i,
  input  logic [psr_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic [psr_pkg::REQ_W-1:0]     in_req_i,
  input  logic [psr_pkg::DT_W-1:0]      in_dt_i,
  input  logic [psr_pkg::IDX_W-1:0]     in_idx_i,
  input  psr_pkg::cmd_t                 cmd_i,
  output psr_pkg::sts_t                 sts_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [psr_pkg::AGE_W-1:0]     out_age_o,
  output logic [psr_pkg::EMIT_W-1:0]    out_emit_o
);
  import psr_pkg::*;

  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);

  // config
  logic              loop_q;
  logic [IVL_W-1:0]  ivl_q;
  logic [AGE_W-1:0]  life_q;
  logic [ACT_W-1:0]  act_q;

  // latched request
  req_e              req_q;
  logic [DT_W-1:0]   dt_q;
  logic [IDX_W-1:0]  idx_q;

  logic [ACC_W-1:0]  acc_q;
  logic [SUM_W-1:0]  dq_q;     // dividend in, quotient out
  logic [ACC_W-1:0]  rm_q;
  logic [DSTEP_W-1:0] dstep_q;

  logic [CW-1:0]     ptr_q, len_q, cnt_q;
  logic              sw_fill_q, rcy_q, wv_q;
  logic [AW-1:0]     wa_q;
  logic [AGE_W-1:0]  fill_q, rdata_q, age_q;

  logic              out_valid_q;
  logic [AGE_W-1:0]  out_age_q;
  logic [EMIT_W-1:0] out_emit_q;

  logic [AGE_W-1:0]  mem [SLOTS];

  logic [IVL_W-1:0]  ivl_eff;
  logic [SUM_W-1:0]  sum, trial;
  logic              ge;
  logic [CW-1:0]     n_use;
  logic              issue;
  logic [AGE_W:0]    aged;
  logic [AGE_W-1:0]  aged_sat;
  logic              expire;
  logic              mem_we;
  logic [AW-1:0]     mem_wa, mem_ra;
  logic [AGE_W-1:0]  mem_wd;
  logic [EMIT_W-1:0] emit_sat;

  assign ivl_eff  = (ivl_q == '0) ? IVL_MIN : ivl_q;
  assign sum      = SUM_W'(acc_q) + SUM_W'(dt_q);
  assign trial    = {rm_q, dq_q[SUM_W-1]};
  assign ge       = trial >= SUM_W'(ivl_eff);
  assign n_use    = (32'(act_q) > SLOTS) ? CW'(SLOTS) : CW'(act_q);
  assign issue    = cmd_i.sweep_run && (ptr_q < len_q);
  assign aged     = (AGE_W+1)'(rdata_q) + (AGE_W+1)'(dt_q);
  assign aged_sat = aged[AGE_W] ? AGE_MAX : aged[AGE_W-1:0];
  assign expire   = rcy_q && (aged_sat > life_q) && (32'(cnt_q) < 32'(dq_q));
  assign mem_we   = sw_fill_q ? issue : wv_q;
  assign mem_wa   = sw_fill_q ? ptr_q[AW-1:0] : wa_q;
  assign mem_wd   = sw_fill_q ? fill_q : (expire ? '0 : aged_sat);
  assign mem_ra   = cmd_i.rd_issue ? AW'(idx_q) : ptr_q[AW-1:0];
  assign emit_sat = (32'(cnt_q) > 32'(EMIT_MAX)) ? EMIT_MAX : EMIT_W'(cnt_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_q <= mem[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_q <= 1'b0;
      ivl_q  <= IVL_W'(100);
      life_q <= AGE_W'(1000);
      act_q  <= ACT_W'(256);
    end else if (cfg_we_i) begin
      unique case (cfg_e'(cfg_idx_i))
        CFG_LOOP:     loop_q <= cfg_data_i[0];
        CFG_INTERVAL: ivl_q  <= cfg_data_i[IVL_W-1:0];
        CFG_LIFE:     life_q <= cfg_data_i;
        CFG_ACTIVE:   act_q  <= cfg_data_i[ACT_W-1:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q <= req_e'(in_req_i);
      dt_q  <= in_dt_i;
      idx_q <= in_idx_i;
    end
    if (cmd_i.div_start) begin
      dq_q    <= sum;
      rm_q    <= '0;
      dstep_q <= '0;
    end else if (cmd_i.div_step) begin
      rm_q    <= ge ? ACC_W'(trial - SUM_W'(ivl_eff)) : trial[ACC_W-1:0];
      dq_q    <= {dq_q[SUM_W-2:0], ge};
      dstep_q <= dstep_q + DSTEP_W'(1);
    end
    if (cmd_i.sweep_start) begin
      sw_fill_q <= cmd_i.sweep_fill;
      rcy_q     <= cmd_i.sweep_recycle;
      fill_q    <= (cmd_i.sweep_cfg && loop_q) ? life_q : '0;
    end
    wa_q <= ptr_q[AW-1:0];
    if (cmd_i.latch) begin
      age_q <= '0;
    end else if (cmd_i.rd_capture) begin
      age_q <= (32'(idx_q) < SLOTS) ? rdata_q : '0;
    end
    if (cmd_i.res_load) begin
      out_age_q  <= age_q;
      out_emit_q <= emit_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      ptr_q       <= '0;
      len_q       <= '0;
      cnt_q       <= '0;
      wv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.acc_clear) begin
        acc_q <= '0;
      end else if (cmd_i.acc_sum) begin
        acc_q <= ACC_W'(sum);
      end else if (cmd_i.acc_rem) begin
        acc_q <= rm_q;
      end
      if (cmd_i.sweep_start) begin
        ptr_q <= '0;
        len_q <= cmd_i.sweep_fill ? CW'(SLOTS) : n_use;
      end else if (issue) begin
        ptr_q <= ptr_q + CW'(1);
      end
      wv_q <= issue && !sw_fill_q;
      if (cmd_i.latch) begin
        cnt_q <= '0;
      end else if (wv_q && !sw_fill_q && expire) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.req        = req_q;
  assign sts_o.loop       = loop_q;
  assign sts_o.sum_gt     = sum > SUM_W'(ivl_eff);
  assign sts_o.div_last   = dstep_q == DSTEP_W'(SUM_W - 1);
  assign sts_o.sweep_done = (ptr_q == len_q) && !wv_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_age_o   = out_age_q;
  assign out_emit_o  = out_emit_q;

endmodule

### sv/particle_slot_recycler.sv
// Particle slot recycler: top level, joins psr_ctrl and psr_dp.
// Depends on psr_pkg, psr_ctrl and psr_dp.
//
//  channel  | dir | transfer when             | payload
//  s_axis   | in  | tvalid & tready           | tuser: req_type; tdata: dt_ms, slot_index
//  m_axis   | out | tvalid & tready           | tdata: age_ms, emitted
//  cfg      | in  | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// Read: one memory read. Loop tick not above the interval: accumulator update. Loop tick
// that emits: divide, then an aging sweep recycling expired slots; one-shot tick: aging
// sweep; sweeps cover N = active slots, one memory port each way. Restart: fills all
// SLOTS. After reset a clearing pass over all SLOTS runs with s_axis_tready low. One item
// at a time; a result waits in the output register, only the next stalls on m_axis_tready.
module particle_slot_recycler #(
  parameter int unsigned SLOTS = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [psr_pkg::CFGI_W-1:0]    cfg_idx_i,
  input  logic [psr_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [23:0]                   s_axis_tdata,   // dt_ms[9:0], slot_index[17:10], zero
  input  logic [psr_pkg::REQ_W-1:0]     s_axis_tuser,   // req_type[1:0]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata    // age_ms[15:0], emitted[24:16], zero
);
  import psr_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic [AGE_W-1:0]  age;
  logic [EMIT_W-1:0] emit;

  psr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .sts_i      (sts),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  psr_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_req_i    (s_axis_tuser),
    .in_dt_i     (s_axis_tdata[DT_W-1:0]),
    .in_idx_i    (s_axis_tdata[DT_W+IDX_W-1:DT_W]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_age_o   (age),
    .out_emit_o  (emit)
  );

  assign m_axis_tdata = {7'd0, emit, age};

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while an item is in flight");

  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (32'(emit) <= SLOTS))
    else $error("emitted count exceeds slot count");

  a_age_or_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (age == '0 || emit == '0))
    else $error("result carries both an age and an emit count");

endmodule

### verif/psr_checker.sv
// Checker for particle_slot_recycler: watches the config port and both streams,
// predicts each result from its own slot table and compares in order.
// Depends on psr_pkg.
`timescale 1ns / 100ps

module psr_checker
  import psr_pkg::*;
#(
  parameter int unsigned SLOTS = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFGI_W-1:0]    cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [23:0]          s_axis_tdata,
  input  logic [REQ_W-1:0]     s_axis_tuser,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [31:0]          m_axis_tdata,
  output int                   errors_o,
  output int                   pending_o
);

  typedef struct packed {
    logic [AGE_W-1:0]  age;
    logic [EMIT_W-1:0] emitted;
  } slot_result_t;

  logic [AGE_W-1:0]  age_table [SLOTS];
  logic [31:0]       emit_acc;
  logic              loop_mode;
  logic [IVL_W-1:0]  interval_ms;
  logic [AGE_W-1:0]  life_ms;
  logic [ACT_W-1:0]  active_cnt;
  slot_result_t      expected_q [$];

  function automatic int unsigned slots_used();
    return (active_cnt > SLOTS) ? SLOTS : active_cnt;
  endfunction

  task automatic age_slots(input int unsigned dt);
    int unsigned sum;
    for (int unsigned i = 0; i < slots_used(); i++) begin
      sum = age_table[i] + dt;
      age_table[i] = (sum > AGE_MAX) ? AGE_MAX : AGE_W'(sum);
    end
  endtask

  task automatic run_request(input logic [REQ_W-1:0] req, input logic [DT_W-1:0] dt,
                             input logic [IDX_W-1:0] idx, output slot_result_t res);
    int unsigned ivl;
    int unsigned emits;
    int unsigned count;
    res = '0;
    case (req)
      REQ_TICK: begin
        if (!loop_mode) begin
          age_slots(dt);
        end else begin
          ivl = (interval_ms == 0) ? 1 : interval_ms;
          emit_acc = emit_acc + dt;
          if (emit_acc > ivl) begin
            age_slots(dt);
            emits = emit_acc / ivl;
            emit_acc = emit_acc % ivl;
            count = 0;
            for (int unsigned i = 0; i < slots_used() && count < emits; i++) begin
              if (age_table[i] > life_ms) begin
                age_table[i] = '0;
                count++;
              end
            end
            res.emitted = (count > EMIT_MAX) ? EMIT_MAX : EMIT_W'(count);
          end
        end
      end
      REQ_READ: begin
        if (idx < SLOTS) res.age = age_table[idx];
      end
      REQ_RESTART: begin
        for (int unsigned i = 0; i < SLOTS; i++) age_table[i] = loop_mode ? life_ms : '0;
        emit_acc = '0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    slot_result_t exp_res;
    slot_result_t got_res;
    if (!rst_ni) begin
      for (int unsigned i = 0; i < SLOTS; i++) age_table[i] = '0;
      emit_acc    = '0;
      loop_mode   = 1'b0;
      interval_ms = IVL_W'(100);
      life_ms     = AGE_W'(1000);
      active_cnt  = ACT_W'(256);
      errors_o    = 0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LOOP:     loop_mode   = cfg_data_i[0];
          CFG_INTERVAL: interval_ms = cfg_data_i[IVL_W-1:0];
          CFG_LIFE:     life_ms     = cfg_data_i[AGE_W-1:0];
          CFG_ACTIVE:   active_cnt  = cfg_data_i[ACT_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        run_request(s_axis_tuser, s_axis_tdata[9:0], s_axis_tdata[17:10], exp_res);
        expected_q.push_back(exp_res);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_res.age     = m_axis_tdata[15:0];
        got_res.emitted = m_axis_tdata[24:16];
        if (expected_q.size() == 0) begin
          $error("unexpected result transfer: age_ms %0d emitted %0d",
                 got_res.age, got_res.emitted);
          errors_o++;
        end else begin
          exp_res = expected_q.pop_front();
          if (got_res.age !== exp_res.age) begin
            $error("age_ms mismatch: expected %0d, actual %0d", exp_res.age, got_res.age);
            errors_o++;
          end
          if (got_res.emitted !== exp_res.emitted) begin
            $error("emitted mismatch: expected %0d, actual %0d",
                   exp_res.emitted, got_res.emitted);
            errors_o++;
          end
        end
      end
    end
    pending_o = expected_q.size();
  end

endmodule

### verif/tb_particle_slot_recycler.sv
// Testbench top for particle_slot_recycler: clock, reset, config phases,
// directed and random requests with random idling on both streams, verdict.
// Depends on psr_pkg, particle_slot_recycler and psr_checker.
`timescale 1ns / 100ps

module tb_particle_slot_recycler;
  import psr_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
  localparam int unsigned      NUM_SLOTS   = 256;
  localparam int               PHASES      = 10;
  localparam int               PHASE_ITEMS = 90;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CFGI_W-1:0]   cfg_idx_i;
  logic [CFG_W-1:0]    cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [23:0]         s_axis_tdata;
  logic [REQ_W-1:0]    s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [31:0]         m_axis_tdata;
  int                  errors;
  int                  pending;

  bit                  calm;
  int unsigned         sent;
  int unsigned         cur_active;

  particle_slot_recycler #(.SLOTS(NUM_SLOTS)) uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  psr_checker #(.SLOTS(NUM_SLOTS)) u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .errors_o(errors), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(30, 150);
  endfunction

  task automatic write_cfg(input cfg_e idx, input int unsigned val);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = CFG_W'(val);
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  // wait for the block to go idle; every request yields a result
  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_config(input int unsigned loop, input int unsigned ivl,
                            input int unsigned life, input int unsigned act);
    drain();
    write_cfg(CFG_LOOP, loop);
    write_cfg(CFG_INTERVAL, ivl);
    write_cfg(CFG_LIFE, life);
    write_cfg(CFG_ACTIVE, act);
    cur_active = act;
  endtask

  task automatic offer(input logic [REQ_W-1:0] req, input int unsigned dt,
                       input int unsigned idx);
    int unsigned gap;
    gap = idle_len();
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = req;
    s_axis_tdata  = {6'd0, IDX_W'(idx), DT_W'(dt)};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic random_config();
    int unsigned loop, ivl, life, act;
    loop = ($urandom_range(0, 9) < 7) ? 1 : 0;
    case ($urandom_range(0, 5))
      0: ivl = 0;
      1: ivl = 1;
      2: ivl = 1000;
      3: ivl = 1023;
      default: ivl = $urandom_range(1, 300);
    endcase
    case ($urandom_range(0, 6))
      0: life = 0;
      1: life = 1;
      2: life = 65535;
      3: life = $urandom_range(0, 65535);
      default: life = $urandom_range(1, 4000);
    endcase
    case ($urandom_range(0, 7))
      0: act = 0;
      1: act = 1;
      2: act = 256;
      3: act = 511;
      4: act = $urandom_range(257, 511);
      default: act = $urandom_range(1, 64);
    endcase
    set_config(loop, ivl, life, act);
  endtask

  task automatic random_item();
    int unsigned r, dt, idx;
    r = $urandom_range(0, 99);
    case ($urandom_range(0, 19))
      0:       dt = $urandom_range(0, 1023);
      1, 2, 3: dt = $urandom_range(0, 10);
      default: dt = $urandom_range(0, 1000);
    endcase
    if (cur_active != 0 && $urandom_range(0, 9) < 7)
      idx = $urandom_range(0, ((cur_active > NUM_SLOTS) ? NUM_SLOTS : cur_active) - 1);
    else
      idx = $urandom_range(0, 255);
    if (r < 55)      offer(REQ_TICK, dt, $urandom_range(0, 255));
    else if (r < 88) offer(REQ_READ, $urandom_range(0, 1023), idx);
    else if (r < 96) offer(REQ_RESTART, $urandom_range(0, 1023), $urandom_range(0, 255));
    else             offer(REQ_UNKNOWN, $urandom_range(0, 1023), $urandom_range(0, 255));
  endtask

  // result side: random stalls, one long hold-off while requests keep coming
  initial begin
    int unsigned stall;
    int unsigned rx_count;
    bit          held;
    m_axis_tready = 1'b0;
    rx_count = 0;
    held     = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = idle_len();
      if (!held && rx_count >= 300) begin
        stall = 600;
        held  = 1'b1;
      end
      if (stall != 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      rx_count++;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_LOOP;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_TICK;
    calm          = 1'b0;
    sent          = 0;
    cur_active    = 256;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: one-shot aging, unknown request
    offer(REQ_READ, 0, 0);
    offer(REQ_TICK, 1000, 0);
    offer(REQ_READ, 0, 255);
    offer(REQ_TICK, 0, 0);
    offer(REQ_UNKNOWN, 1023, 255);
    offer(REQ_READ, 0, 255);

    // zero interval, zero lifetime, active count past the table
    set_config(1, 0, 0, 300);
    offer(REQ_RESTART, 0, 0);
    offer(REQ_TICK, 1, 0);
    offer(REQ_TICK, 1, 0);
    offer(REQ_READ, 0, 1);
    offer(REQ_READ, 0, 2);
    offer(REQ_TICK, 1023, 0);
    offer(REQ_READ, 0, 255);

    // age saturation, accumulator exactly at the interval, read beyond active
    set_config(1, 1000, 65535, 1);
    offer(REQ_RESTART, 0, 0);
    offer(REQ_TICK, 1000, 0);
    offer(REQ_TICK, 1, 0);
    offer(REQ_READ, 0, 0);
    offer(REQ_READ, 0, 1);

    // no active slots, one-shot restart
    set_config(0, 1023, 1, 0);
    offer(REQ_TICK, 700, 0);
    offer(REQ_RESTART, 0, 0);
    offer(REQ_READ, 0, 100);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_config(1, 100, 1000, 256);
        1: set_config(0, 1, 0, 16);
        2: set_config(1, 1, 1, 511);
        3: set_config(1, 50, 2000, 32);
        default: random_config();
      endcase
      calm = (p == 3 || p == 7);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 5 && i == PHASE_ITEMS / 2) begin
          s_axis_tvalid = 1'b0;
          while (pending != 0) @(negedge clk_i);
        end
        random_item();
      end
    end
    s_axis_tvalid = 1'b0;
    calm = 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
